[sv/fece_pkg.sv]
`timescale 1ns / 1ps

package fece_pkg;

  // default store geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 66;

  // screen pixel to cell mapping
  localparam int CELL_SHIFT = 2;

  localparam int HEAT_W = 8;

  // cooling steps and seed heat
  localparam logic [HEAT_W-1:0] COOL_BIG_STEP   = 8'd12;
  localparam logic [HEAT_W-1:0] COOL_SMALL_STEP = 8'd4;
  localparam logic [HEAT_W-1:0] SEED_HOT_HEAT   = 8'd255;

  typedef enum logic [1:0] {
    REQ_ADVANCE = 2'd0,
    REQ_SEED    = 2'd1,
    REQ_READ    = 2'd2,
    REQ_NONE    = 2'd3
  } req_kind_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADV_RD0,
    ST_ADV_RD1,
    ST_ADV_RD2,
    ST_ADV_RD3,
    ST_ADV_SUM,
    ST_ADV_COOL,
    ST_SEED_A,
    ST_SEED_B,
    ST_READ_ISSUE,
    ST_READ_DATA,
    ST_DONE
  } ctrl_state_e;

  typedef enum logic [1:0] {
    ALU_HOLD,
    ALU_LOAD,
    ALU_ADD
  } alu_op_e;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } ram_ctl_t;

  typedef struct packed {
    alu_op_e op;
    logic    zero;
  } alu_ctl_t;

  typedef struct packed {
    logic ready;
    logic res_load;
    logic adv_done;
  } ctrl_stat_t;

  // cooling of one cell
  function automatic logic [HEAT_W-1:0] cool_heat(input logic [HEAT_W-1:0] v);
    logic [HEAT_W-1:0] r;
    if (v >= COOL_BIG_STEP) begin
      r = v - COOL_BIG_STEP;
    end else if (v >= COOL_SMALL_STEP) begin
      r = v - COOL_SMALL_STEP;
    end else begin
      r = '0;
    end
    return r;
  endfunction

  // fire palette, 8-bit red, green, blue per heat level
  localparam logic [7:0] PALETTE [256][3] = '{
    '{0,0,0},'{0,0,24},'{0,0,24},'{0,0,28},
    '{0,0,32},'{0,0,32},'{0,0,36},'{0,0,40},
    '{8,0,40},'{16,0,36},'{24,0,36},'{32,0,32},
    '{40,0,28},'{48,0,28},'{56,0,24},'{64,0,20},
    '{72,0,20},'{80,0,16},'{88,0,16},'{96,0,12},
    '{104,0,8},'{112,0,8},'{120,0,4},'{128,0,0},
    '{128,0,0},'{132,0,0},'{136,0,0},'{140,0,0},
    '{144,0,0},'{144,0,0},'{148,0,0},'{152,0,0},
    '{156,0,0},'{160,0,0},'{160,0,0},'{164,0,0},
    '{168,0,0},'{172,0,0},'{176,0,0},'{180,0,0},
    '{184,4,0},'{188,4,0},'{192,8,0},'{196,8,0},
    '{200,12,0},'{204,12,0},'{208,16,0},'{212,16,0},
    '{216,20,0},'{220,20,0},'{224,24,0},'{228,24,0},
    '{232,28,0},'{236,28,0},'{240,32,0},'{244,32,0},
    '{252,36,0},'{252,36,0},'{252,40,0},'{252,40,0},
    '{252,44,0},'{252,44,0},'{252,48,0},'{252,48,0},
    '{252,52,0},'{252,52,0},'{252,56,0},'{252,56,0},
    '{252,60,0},'{252,60,0},'{252,64,0},'{252,64,0},
    '{252,68,0},'{252,68,0},'{252,72,0},'{252,72,0},
    '{252,76,0},'{252,76,0},'{252,80,0},'{252,80,0},
    '{252,84,0},'{252,84,0},'{252,88,0},'{252,88,0},
    '{252,92,0},'{252,96,0},'{252,96,0},'{252,100,0},
    '{252,100,0},'{252,104,0},'{252,104,0},'{252,108,0},
    '{252,108,0},'{252,112,0},'{252,112,0},'{252,116,0},
    '{252,116,0},'{252,120,0},'{252,120,0},'{252,124,0},
    '{252,124,0},'{252,128,0},'{252,128,0},'{252,132,0},
    '{252,132,0},'{252,136,0},'{252,136,0},'{252,140,0},
    '{252,140,0},'{252,144,0},'{252,144,0},'{252,148,0},
    '{252,152,0},'{252,152,0},'{252,156,0},'{252,156,0},
    '{252,160,0},'{252,160,0},'{252,164,0},'{252,164,0},
    '{252,168,0},'{252,168,0},'{252,172,0},'{252,172,0},
    '{252,176,0},'{252,176,0},'{252,180,0},'{252,180,0},
    '{252,184,0},'{252,184,0},'{252,188,0},'{252,188,0},
    '{252,192,0},'{252,192,0},'{252,196,0},'{252,196,0},
    '{252,200,0},'{252,200,0},'{252,204,0},'{252,208,0},
    '{252,208,0},'{252,208,0},'{252,208,0},'{252,208,0},
    '{252,212,0},'{252,212,0},'{252,212,0},'{252,212,0},
    '{252,216,0},'{252,216,0},'{252,216,0},'{252,216,0},
    '{252,216,0},'{252,220,0},'{252,220,0},'{252,220,0},
    '{252,220,0},'{252,224,0},'{252,224,0},'{252,224,0},
    '{252,224,0},'{252,228,0},'{252,228,0},'{252,228,0},
    '{252,228,0},'{252,228,0},'{252,232,0},'{252,232,0},
    '{252,232,0},'{252,232,0},'{252,236,0},'{252,236,0},
    '{252,236,0},'{252,236,0},'{252,240,0},'{252,240,0},
    '{252,240,0},'{252,240,0},'{252,240,0},'{252,244,0},
    '{252,244,0},'{252,244,0},'{252,244,0},'{252,248,0},
    '{252,248,0},'{252,248,0},'{252,248,0},'{252,252,0},
    '{252,252,4},'{252,252,8},'{252,252,12},'{252,252,16},
    '{252,252,20},'{252,252,24},'{252,252,28},'{252,252,32},
    '{252,252,36},'{252,252,40},'{252,252,40},'{252,252,44},
    '{252,252,48},'{252,252,52},'{252,252,56},'{252,252,60},
    '{252,252,64},'{252,252,68},'{252,252,72},'{252,252,76},
    '{252,252,80},'{252,252,84},'{252,252,84},'{252,252,88},
    '{252,252,92},'{252,252,96},'{252,252,100},'{252,252,104},
    '{252,252,108},'{252,252,112},'{252,252,116},'{252,252,120},
    '{252,252,124},'{252,252,124},'{252,252,128},'{252,252,132},
    '{252,252,136},'{252,252,140},'{252,252,144},'{252,252,148},
    '{252,252,152},'{252,252,156},'{252,252,160},'{252,252,164},
    '{252,252,168},'{252,252,168},'{252,252,172},'{252,252,176},
    '{252,252,180},'{252,252,184},'{252,252,188},'{252,252,192},
    '{252,252,196},'{252,252,200},'{252,252,204},'{252,252,208},
    '{252,252,208},'{252,252,212},'{252,252,216},'{252,252,220},
    '{252,252,224},'{252,252,228},'{252,252,232},'{252,252,236},
    '{252,252,240},'{252,252,244},'{252,252,248},'{252,252,252}
  };

endpackage

[sv/fire_effect_cell_engine_unit.sv]
`timescale 1ns / 1ps

// Fire effect cell engine: a ROWS x COLUMNS store of 8-bit heat cells.
// Input channel (in_valid_i / in_stall_o) carries one request per beat:
// advance one frame, seed one bottom column, or read one screen pixel.
// Output channel (out_valid_o / out_stall_i) returns one beat per request:
// the read cell's heat and its palette color in RGB565 parts, all zeros
// for advance and seed requests.
// After reset the store is cleared one cell per cycle; in_stall_o stays
// high meanwhile. One request is worked on at a time through the
// single-port heat memory. An advance visits (ROWS-1)*COLUMNS cells,
// each with four reads into the shared adder and two writes. A seed
// makes two writes; a pixel read issues the address, reads the memory,
// then looks up the palette. The next request can be accepted in the
// cycle after the previous result is loaded.
// A stalled result stays in the output register; a finished request waits
// for that register to drain before the block takes new beats.
module fire_effect_cell_engine_unit import fece_pkg::*; #(
  parameter  int COLUMNS = COLUMNS_DEF,
  parameter  int ROWS    = ROWS_DEF,
  localparam int TOTAL   = ROWS * COLUMNS,
  localparam int ADDR_W  = $clog2(TOTAL)
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] req_type_i,
  input  logic [6:0] column_i,
  input  logic       change_seed_i,
  input  logic       hot_i,
  input  logic [8:0] pixel_x_i,
  input  logic [7:0] pixel_y_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] heat_o,
  output logic [4:0] red_o,
  output logic [5:0] green_o,
  output logic [4:0] blue_o
);

  ctrl_stat_t        stat;
  ram_ctl_t          ram_ctl;
  alu_ctl_t          alu_ctl;
  logic [ADDR_W-1:0] ram_addr;
  logic [HEAT_W-1:0] ram_wdata;
  logic [HEAT_W-1:0] ram_rdata;
  logic [HEAT_W-1:0] avg;
  logic [HEAT_W-1:0] cool;
  logic [HEAT_W-1:0] res_heat;

  logic              in_accept;
  logic              out_free;

  req_kind_e         kind_q, kind_d;
  logic [6:0]        col_q, col_d;
  logic              seed_val_q, seed_val_d;
  logic [7:0]        pix_row_q, pix_row_d;
  logic [8:0]        pix_col_q, pix_col_d;
  logic              seed_hot_q, seed_hot_d;

  logic              out_valid_q, out_valid_d;
  logic [7:0]        heat_q, heat_d;
  logic [4:0]        red_q, red_d;
  logic [5:0]        green_q, green_d;
  logic [4:0]        blue_q, blue_d;

  assign in_stall_o = !stat.ready;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // request capture and running seed
  always_comb begin
    kind_d     = kind_q;
    col_d      = col_q;
    seed_val_d = seed_val_q;
    pix_row_d  = pix_row_q;
    pix_col_d  = pix_col_q;
    seed_hot_d = seed_hot_q;
    if (in_accept) begin
      kind_d     = req_kind_e'(req_type_i);
      col_d      = column_i;
      seed_val_d = change_seed_i ? hot_i : seed_hot_q;
      pix_row_d  = pixel_y_i >> CELL_SHIFT;
      pix_col_d  = pixel_x_i >> CELL_SHIFT;
      if ((req_kind_e'(req_type_i) == REQ_SEED) && change_seed_i) begin
        seed_hot_d = hot_i;
      end
    end
    if (stat.adv_done) begin
      seed_hot_d = 1'b0;
    end
  end

  // result beat with palette lookup
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    heat_d      = heat_q;
    red_d       = red_q;
    green_d     = green_q;
    blue_d      = blue_q;
    if (stat.res_load) begin
      out_valid_d = 1'b1;
      heat_d      = res_heat;
      red_d       = PALETTE[res_heat][0][7:3];
      green_d     = PALETTE[res_heat][1][7:2];
      blue_d      = PALETTE[res_heat][2][7:3];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_hot_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      seed_hot_q  <= seed_hot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    col_q      <= col_d;
    seed_val_q <= seed_val_d;
    pix_row_q  <= pix_row_d;
    pix_col_q  <= pix_col_d;
    heat_q     <= heat_d;
    red_q      <= red_d;
    green_q    <= green_d;
    blue_q     <= blue_d;
  end

  assign out_valid_o = out_valid_q;
  assign heat_o      = heat_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;

  // sequencer
  fece_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_accept),
    .kind_i      (kind_d),
    .seed_col_i  (col_q),
    .seed_hot_i  (seed_val_q),
    .pix_row_i   (pix_row_q),
    .pix_col_i   (pix_col_q),
    .out_free_i  (out_free),
    .avg_i       (avg),
    .cool_i      (cool),
    .rdata_i     (ram_rdata),
    .ram_ctl_o   (ram_ctl),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .alu_ctl_o   (alu_ctl),
    .stat_o      (stat),
    .heat_o      (res_heat)
  );

  // shared neighbor adder and cooling
  fece_cell_alu u_alu (
    .clk_i     (clk_i),
    .ctl_i     (alu_ctl),
    .operand_i (ram_rdata),
    .avg_o     (avg),
    .cool_o    (cool)
  );

  // heat store
  fece_heat_ram #(
    .DEPTH (TOTAL)
  ) u_ram (
    .clk_i   (clk_i),
    .ctl_i   (ram_ctl),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // block goes busy right after taking a beat
  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o
  ) else $error("block still ready after accepting a beat");

  // single memory port: never read and write together
  a_ram_one_access: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !(ram_ctl.wr_en && ram_ctl.rd_en)
  ) else $error("heat memory read and written in one cycle");

  // running seed is cleared when a frame advance completes
  a_seed_cleared: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    stat.adv_done |=> !seed_hot_q
  ) else $error("running seed not cleared after advance");

  // a result is only loaded into a free output register
  a_load_free: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    stat.res_load |-> (!out_valid_q || !out_stall_i)
  ) else $error("result loaded over a stalled beat");

endmodule

[sv/fece_heat_ram.sv]
`timescale 1ns / 1ps

module fece_heat_ram import fece_pkg::*; #(
  parameter  int DEPTH  = ROWS_DEF * COLUMNS_DEF,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  ram_ctl_t          ctl_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [HEAT_W-1:0] wdata_i,
  output logic [HEAT_W-1:0] rdata_o
);

  logic [HEAT_W-1:0] mem [DEPTH];
  logic [HEAT_W-1:0] rdata_q;

  // single port heat store, registered read
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[addr_i] <= wdata_i;
    end
    if (ctl_i.rd_en) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/fece_cell_alu.sv]
`timescale 1ns / 1ps

module fece_cell_alu import fece_pkg::*; (
  input  logic              clk_i,
  input  alu_ctl_t          ctl_i,
  input  logic [HEAT_W-1:0] operand_i,
  output logic [HEAT_W-1:0] avg_o,
  output logic [HEAT_W-1:0] cool_o
);

  logic [HEAT_W+1:0] acc_q;
  logic [HEAT_W-1:0] center_q;
  logic [HEAT_W-1:0] opnd;
  logic [HEAT_W+1:0] sum;

  // neighbor outside the store reads as zero
  assign opnd = ctl_i.zero ? '0 : operand_i;
  assign sum  = acc_q + (HEAT_W+2)'(opnd);

  // four-neighbor accumulator and center cell
  always_ff @(posedge clk_i) begin
    case (ctl_i.op)
      ALU_LOAD: begin
        acc_q    <= (HEAT_W+2)'(opnd);
        center_q <= opnd;
      end
      ALU_ADD: begin
        acc_q <= sum;
      end
      default: begin
      end
    endcase
  end

  assign avg_o  = sum[HEAT_W+1:2];
  assign cool_o = cool_heat(center_q);

endmodule

[sv/fece_ctrl.sv]
`timescale 1ns / 1ps

module fece_ctrl import fece_pkg::*; #(
  parameter  int COLUMNS = COLUMNS_DEF,
  parameter  int ROWS    = ROWS_DEF,
  localparam int TOTAL   = ROWS * COLUMNS,
  localparam int ADDR_W  = $clog2(TOTAL)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  req_kind_e         kind_i,
  input  logic [6:0]        seed_col_i,
  input  logic              seed_hot_i,
  input  logic [7:0]        pix_row_i,
  input  logic [8:0]        pix_col_i,
  input  logic              out_free_i,
  input  logic [HEAT_W-1:0] avg_i,
  input  logic [HEAT_W-1:0] cool_i,
  input  logic [HEAT_W-1:0] rdata_i,
  output ram_ctl_t          ram_ctl_o,
  output logic [ADDR_W-1:0] ram_addr_o,
  output logic [HEAT_W-1:0] ram_wdata_o,
  output alu_ctl_t          alu_ctl_o,
  output ctrl_stat_t        stat_o,
  output logic [HEAT_W-1:0] heat_o
);

  localparam int CALC_W = ADDR_W + 1;
  localparam logic [ADDR_W-1:0] SEED_BASE = ADDR_W'((ROWS - 2) * COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(TOTAL - 1);

  ctrl_state_e       state_q, state_d;
  logic [ADDR_W-1:0] cur_q, cur_d;
  logic              zflag_q, zflag_d;
  logic [HEAT_W-1:0] res_heat_q, res_heat_d;

  logic [CALC_W-1:0] offset;
  logic [CALC_W-1:0] calc;
  logic              oor;
  logic              last;
  logic              seed_ok;
  logic [ADDR_W-1:0] seed_addr;
  logic [HEAT_W-1:0] seed_heat;
  logic              pix_ok;
  logic [ADDR_W-1:0] pix_addr;

  // neighbor offset from the cursor, one shared address adder
  always_comb begin
    case (state_q)
      ST_ADV_RD1: offset = '1;
      ST_ADV_RD2: offset = CALC_W'(1);
      ST_ADV_RD3: offset = CALC_W'(COLUMNS);
      ST_ADV_SUM: offset = CALC_W'(-COLUMNS);
      default:    offset = '0;
    endcase
  end

  assign calc = {1'b0, cur_q} + offset;
  assign oor  = (calc >= CALC_W'(TOTAL));
  assign last = (cur_q == LAST_CELL);

  // seed and pixel addressing
  assign seed_ok   = ({2'b0, seed_col_i} < 9'(COLUMNS));
  assign seed_addr = SEED_BASE + ADDR_W'(seed_col_i);
  assign seed_heat = seed_hot_i ? SEED_HOT_HEAT : '0;
  assign pix_ok    = ({1'b0, pix_row_i} < 9'(ROWS)) && (pix_col_i < 9'(COLUMNS));
  assign pix_addr  = ADDR_W'(pix_row_i) * ADDR_W'(COLUMNS) + ADDR_W'(pix_col_i);

  // next state, cursor and result heat
  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    res_heat_d = res_heat_q;
    case (state_q)
      ST_CLEAR: begin
        cur_d = cur_q + 1'b1;
        if (last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          cur_d      = ADDR_W'(COLUMNS);
          res_heat_d = '0;
          case (kind_i)
            REQ_ADVANCE: state_d = ST_ADV_RD0;
            REQ_SEED:    state_d = ST_SEED_A;
            REQ_READ:    state_d = ST_READ_ISSUE;
            default:     state_d = ST_DONE;
          endcase
        end
      end
      ST_ADV_RD0:  state_d = ST_ADV_RD1;
      ST_ADV_RD1:  state_d = ST_ADV_RD2;
      ST_ADV_RD2:  state_d = ST_ADV_RD3;
      ST_ADV_RD3:  state_d = ST_ADV_SUM;
      ST_ADV_SUM:  state_d = ST_ADV_COOL;
      ST_ADV_COOL: begin
        if (last) begin
          state_d = ST_DONE;
        end else begin
          cur_d   = cur_q + 1'b1;
          state_d = ST_ADV_RD0;
        end
      end
      ST_SEED_A:     state_d = ST_SEED_B;
      ST_SEED_B:     state_d = ST_DONE;
      ST_READ_ISSUE: state_d = ST_READ_DATA;
      ST_READ_DATA: begin
        res_heat_d = pix_ok ? rdata_i : '0;
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // memory, alu and status outputs per state
  always_comb begin
    ram_ctl_o      = '0;
    ram_addr_o     = calc[ADDR_W-1:0];
    ram_wdata_o    = '0;
    alu_ctl_o.op   = ALU_HOLD;
    alu_ctl_o.zero = zflag_q;
    zflag_d        = 1'b0;
    stat_o         = '0;
    case (state_q)
      ST_CLEAR: begin
        ram_ctl_o.wr_en = 1'b1;
        ram_addr_o      = cur_q;
      end
      ST_IDLE: begin
        stat_o.ready = 1'b1;
      end
      ST_ADV_RD0: begin
        ram_ctl_o.rd_en = !oor;
        zflag_d         = oor;
      end
      ST_ADV_RD1: begin
        ram_ctl_o.rd_en = !oor;
        zflag_d         = oor;
        alu_ctl_o.op    = ALU_LOAD;
      end
      ST_ADV_RD2, ST_ADV_RD3: begin
        ram_ctl_o.rd_en = !oor;
        zflag_d         = oor;
        alu_ctl_o.op    = ALU_ADD;
      end
      ST_ADV_SUM: begin
        ram_ctl_o.wr_en = 1'b1;
        ram_wdata_o     = avg_i;
      end
      ST_ADV_COOL: begin
        ram_ctl_o.wr_en = 1'b1;
        ram_addr_o      = cur_q;
        ram_wdata_o     = cool_i;
        stat_o.adv_done = last;
      end
      ST_SEED_A: begin
        ram_ctl_o.wr_en = seed_ok;
        ram_addr_o      = seed_addr;
        ram_wdata_o     = seed_heat;
      end
      ST_SEED_B: begin
        ram_ctl_o.wr_en = seed_ok;
        ram_addr_o      = seed_addr + ADDR_W'(COLUMNS);
        ram_wdata_o     = seed_heat;
      end
      ST_READ_ISSUE: begin
        ram_ctl_o.rd_en = pix_ok;
        ram_addr_o      = pix_addr;
      end
      ST_DONE: begin
        stat_o.res_load = out_free_i;
      end
      default: begin
      end
    endcase
  end

  assign heat_o = res_heat_q;

  // sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cur_q   <= '0;
      zflag_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      zflag_q <= zflag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_heat_q <= res_heat_d;
  end

endmodule
